// ===== src/u2jue_pkg.sv =====
// Package for the UTF-8 to JSON escape block.
// Holds the payload structs, the character codes and the helpers that build escape bytes.
// No dependencies.
`default_nettype none

package u2jue_pkg;

    // One input transaction: a raw string byte and its end mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_item_t;

    // One output transaction: an escaped text byte and the terminator mark
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // What a burst emits in place of escapes: nothing, the plain byte, or a backslash and the byte
    typedef enum logic [1:0] {
        CH_NONE,
        CH_PLAIN,
        CH_QUOTED
    } char_mode_t;

    localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_U         = 8'h75;
    localparam logic [7:0] CHR_ZERO      = 8'h30;
    localparam logic [7:0] CHR_A         = 8'h61;
    localparam logic [7:0] CHR_NUL       = 8'h00;

    localparam logic [15:0] SURR_HIGH     = 16'hd800;
    localparam logic [15:0] SURR_LOW      = 16'hdc00;
    localparam logic [20:0] SUPPLEMENTARY = 21'h010000;

    localparam int unsigned ESC_LEN = 6;

    // Lower-case hex digit for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10)
            res = CHR_ZERO + {4'd0, nib};
        else
            res = CHR_A + {4'd0, nib} - 8'd10;
        return res;
    endfunction

    // Byte at position pos (0..5) of a backslash-u escape of v
    function automatic logic [7:0] esc_byte(input logic [15:0] v, input logic [2:0] pos);
        logic [7:0] res;
        case (pos)
            3'd0:    res = CHR_BACKSLASH;
            3'd1:    res = CHR_U;
            3'd2:    res = hex_digit(v[15:12]);
            3'd3:    res = hex_digit(v[11:8]);
            3'd4:    res = hex_digit(v[7:4]);
            3'd5:    res = hex_digit(v[3:0]);
            default: res = CHR_NUL;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/utf8_to_json_unicode_escape.sv =====
// The first result of an input transaction passes through the burst register into the output
// register; the rest of its burst follows one byte per cycle while esc_stall is low.
// An input byte yields N output bytes (0 to 13); the burst emitter sends one output byte
// per cycle while esc_stall is low, which sets the rate.
// The next input is taken in the cycle the last byte of the current burst moves out.
// Reset (rst_n, asynchronous, active low) clears the decode state, burst and output valid.
// Depends on u2jue_pkg.
`default_nettype none

module utf8_to_json_unicode_escape (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire u2jue_pkg::in_item_t  byte_item,
    output logic                      esc_valid,
    input  wire logic                 esc_stall,
    output u2jue_pkg::out_item_t      esc_item
);
    import u2jue_pkg::*;

    // Decode state
    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  seqlen_reg, seqlen_next;
    logic [20:0] acc_reg, acc_next;

    // Burst register: what one input transaction emits
    logic        burst_valid_reg;
    char_mode_t  mode_reg, mode_next;
    logic [7:0]  char_reg, char_next;
    logic [15:0] v1_reg, v1_next;
    logic [15:0] v2_reg, v2_next;
    logic        term_reg, term_next;
    logic [3:0]  len_reg, len_next;
    logic [3:0]  idx_reg;

    // Output register
    logic        out_valid_reg;
    out_item_t   out_reg, out_next;

    logic        accept;
    logic        out_load;
    logic        burst_done;
    logic        burst_nonempty;
    logic [1:0]  esc_cnt;
    logic [20:0] acc_gather;
    logic [20:0] acc_off;
    logic [1:0]  pend_dec;
    logic [2:0]  esc_pos;

    // Handshake
    assign out_load   = burst_valid_reg && (!out_valid_reg || !esc_stall);
    assign burst_done = out_load && (idx_reg == len_reg - 4'd1);
    assign byte_stall = burst_valid_reg && !burst_done;
    assign accept     = byte_valid && !byte_stall;
    assign esc_valid  = out_valid_reg;
    assign esc_item   = out_reg;

    // Input decode: next state and burst contents
    always_comb
    begin
        pend_next   = pend_reg;
        seqlen_next = seqlen_reg;
        acc_next    = acc_reg;
        mode_next   = CH_NONE;
        char_next   = byte_item.data_byte;
        v1_next     = acc_reg[15:0];
        v2_next     = acc_reg[15:0];
        esc_cnt     = 2'd0;
        term_next   = byte_item.end_of_string;
        acc_gather  = {acc_reg[14:0], byte_item.data_byte[5:0]};
        acc_off     = acc_gather - SUPPLEMENTARY;
        pend_dec    = pend_reg - 2'd1;

        if (pend_reg != 2'd0)
        begin
            acc_next  = acc_gather;
            pend_next = pend_dec;
            if (pend_dec == 2'd0)
            begin
                if (seqlen_reg == 2'd3 && acc_gather >= SUPPLEMENTARY)
                begin
                    v1_next = SURR_HIGH | {6'd0, acc_off[19:10]};
                    v2_next = SURR_LOW  | {6'd0, acc_off[9:0]};
                    esc_cnt = 2'd2;
                end
                else
                begin
                    v1_next = acc_gather[15:0];
                    esc_cnt = 2'd1;
                end
                seqlen_next = 2'd0;
                acc_next    = '0;
            end
        end
        else if (byte_item.data_byte == CHR_BACKSLASH || byte_item.data_byte == CHR_QUOTE)
        begin
            mode_next = CH_QUOTED;
        end
        else if (!byte_item.data_byte[7])
        begin
            mode_next = CH_PLAIN;
        end
        else if (byte_item.data_byte[7:5] == 3'b110)
        begin
            acc_next    = {16'd0, byte_item.data_byte[4:0]};
            pend_next   = 2'd1;
            seqlen_next = 2'd1;
        end
        else if (byte_item.data_byte[7:4] == 4'b1110)
        begin
            acc_next    = {17'd0, byte_item.data_byte[3:0]};
            pend_next   = 2'd2;
            seqlen_next = 2'd2;
        end
        else
        begin
            acc_next    = {18'd0, byte_item.data_byte[2:0]};
            pend_next   = 2'd3;
            seqlen_next = 2'd3;
        end

        // End mark drops any open sequence
        if (byte_item.end_of_string)
        begin
            pend_next   = 2'd0;
            seqlen_next = 2'd0;
            acc_next    = '0;
        end

        case (mode_next)
            CH_PLAIN:  len_next = 4'd1;
            CH_QUOTED: len_next = 4'd2;
            default:   len_next = 4'd0;
        endcase
        case (esc_cnt)
            2'd1:    len_next = len_next + 4'(ESC_LEN);
            2'd2:    len_next = len_next + 4'(2 * ESC_LEN);
            default: len_next = len_next;
        endcase
        len_next       = len_next + {3'd0, term_next};
        burst_nonempty = (len_next != 4'd0);
    end

    // Byte selection for the current burst position
    always_comb
    begin
        esc_pos  = (idx_reg < 4'(ESC_LEN)) ? idx_reg[2:0] : 3'(idx_reg - 4'(ESC_LEN));
        out_next = out_reg;
        if (term_reg && idx_reg == len_reg - 4'd1)
        begin
            out_next.out_byte = CHR_NUL;
            out_next.out_last = 1'b1;
        end
        else
        begin
            out_next.out_last = 1'b0;
            case (mode_reg)
                CH_PLAIN:  out_next.out_byte = char_reg;
                CH_QUOTED: out_next.out_byte = (idx_reg == 4'd0) ? CHR_BACKSLASH : char_reg;
                default:   out_next.out_byte = (idx_reg < 4'(ESC_LEN)) ?
                                               esc_byte(v1_reg, esc_pos) :
                                               esc_byte(v2_reg, esc_pos);
            endcase
        end
    end

    // Decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 2'd0;
            seqlen_reg <= 2'd0;
            acc_reg    <= '0;
        end
        else if (accept)
        begin
            pend_reg   <= pend_next;
            seqlen_reg <= seqlen_next;
            acc_reg    <= acc_next;
        end
    end

    // Burst control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= 4'd0;
        end
        else if (accept)
        begin
            burst_valid_reg <= burst_nonempty;
            idx_reg         <= 4'd0;
        end
        else if (burst_done)
        begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= 4'd0;
        end
        else if (out_load)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    // Burst payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_next;
            char_reg <= char_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            term_reg <= term_next;
            len_reg  <= len_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!esc_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    // Burst position never runs past its length
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (len_reg != 4'd0 && idx_reg < len_reg))
        else $error("burst index out of range");

    // An open sequence always has a kind
    a_pend_kind: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd0 |-> seqlen_reg != 2'd0)
        else $error("pending bytes without sequence kind");

    // End of string leaves no open sequence
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && byte_item.end_of_string) |=>
        (pend_reg == 2'd0 && seqlen_reg == 2'd0 && acc_reg == '0))
        else $error("state not cleared at end of string");

endmodule

`default_nettype wire
